// ----- rtl/integer_calculator_key_engine_defines.svh -----
// Assertion macros for the calculator key engine.
`ifndef INTEGER_CALCULATOR_KEY_ENGINE_DEFINES_SVH
`define INTEGER_CALCULATOR_KEY_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define ICKE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ICKE_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICKE_ASSERT(label, clk, rst_n, prop, msg)
`define ICKE_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ----- rtl/icke_pkg.sv -----
// Shared types and constants for the calculator key engine.
package icke_pkg;
    localparam int unsigned KindW = 4;
    localparam int unsigned DataW = 16;
    localparam int unsigned OpW = 3;

    localparam logic [KindW-1:0] KIND_DIGIT  = 4'd0;
    localparam logic [KindW-1:0] KIND_POINT  = 4'd1;
    localparam logic [KindW-1:0] KIND_EQUALS = 4'd2;
    localparam logic [KindW-1:0] KIND_CLEAR  = 4'd3;
    localparam logic [KindW-1:0] KIND_NEGATE = 4'd4;
    localparam logic [KindW-1:0] KIND_SQRT   = 4'd5;
    localparam logic [KindW-1:0] KIND_POWER  = 4'd6;
    localparam logic [KindW-1:0] KIND_ADD    = 4'd7;
    localparam logic [KindW-1:0] KIND_SUB    = 4'd8;
    localparam logic [KindW-1:0] KIND_MUL    = 4'd9;
    localparam logic [KindW-1:0] KIND_DIV    = 4'd10;

    localparam logic [OpW-1:0] OP_NONE = 3'd0;
    localparam logic [OpW-1:0] OP_ADD  = 3'd1;
    localparam logic [OpW-1:0] OP_SUB  = 3'd2;
    localparam logic [OpW-1:0] OP_MUL  = 3'd3;
    localparam logic [OpW-1:0] OP_DIV  = 3'd4;
    localparam logic [OpW-1:0] OP_POW  = 3'd5;

    localparam logic signed [DataW-1:0] DigitLimit = 16'sd3276;
    localparam logic [DataW-1:0] PowNumer = 16'd32767;
    localparam logic [3:0] PowMaxSteps = 4'd15;
    localparam logic [3:0] SqrtMaxRounds = 4'd10;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [3:0] digit;
    } key_t;

    typedef struct packed {
        logic signed [DataW-1:0] display;
        logic [OpW-1:0] pending_operation;
        logic entry_fresh;
    } res_t;
endpackage

// ----- rtl/icke_stream_if.sv -----
// Valid/ready channel carrying one packed item.
interface icke_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/integer_calculator_key_engine.sv -----
// Calculator key engine: key sequencer with one shared divider and two multipliers.
//  channel | dir | payload
//  key_in  | in  | kind, digit
//  res_out | out | display, pending_operation, entry_fresh
// Simple keys go through decode to the result; operators with nothing pending
// also pass a post step, and a divide runs the 16-step bit-serial restoring divider.
// Power runs up to 14 multiplies plus one divide for the limit;
// square root runs up to 10 rounds of one divide each.
// The key input is not ready from acceptance until the result is taken.
// Reset (rst_n low) clears display, operand and pending op and sets fresh.
`include "integer_calculator_key_engine_defines.svh"
module integer_calculator_key_engine (
    input logic clk,
    input logic rst_n,
    icke_stream_if.sink key_in,
    icke_stream_if.source res_out
);
    import icke_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_FINISH, S_DIV, S_DIV_DONE, S_POW_LIM, S_POW_MUL,
        S_SQ_DIV, S_SQ_STEP, S_POST, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        DU_OPDIV, DU_POWLIM, DU_SQRT
    } du_use_t;

    state_t state_reg;
    du_use_t use_reg;
    logic [DataW-1:0] disp_reg, stor_reg;
    logic [OpW-1:0] pend_reg;
    logic fresh_reg;
    logic [KindW-1:0] kind_reg;
    logic [3:0] dig_reg;
    // divider
    logic [DataW-1:0] quo_reg, den_reg;
    logic [DataW:0] rem_reg;
    logic [4:0] dcnt_reg;
    logic qneg_reg;
    // power / sqrt
    logic signed [DataW-1:0] acc_reg, base_reg, lim_reg;
    logic [DataW-1:0] exp_reg;
    logic [3:0] step_reg;

    logic signed [DataW-1:0] s_s, d_s;
    logic [DataW:0] rem_sh, rem_sub;
    logic signed [2*DataW-1:0] prod;
    logic signed [DataW:0] sq_sum;
    logic [DataW-1:0] sq_new;

    assign s_s = stor_reg;
    assign d_s = disp_reg;
    assign rem_sh = {rem_reg[DataW-1:0], quo_reg[DataW-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign prod = acc_reg * base_reg;
    assign sq_sum = {acc_reg[DataW-1], acc_reg} + {1'b0, quo_reg};
    assign sq_new = sq_sum[DataW:1];

    assign key_in.ready = (state_reg == S_IDLE);
    assign res_out.valid = (state_reg == S_OUT);
    assign res_out.data = '{display: disp_reg, pending_operation: pend_reg,
                            entry_fresh: fresh_reg};

    function automatic logic [DataW-1:0] mag16(input logic [DataW-1:0] v);
        mag16 = v[DataW-1] ? (~v + 1'b1) : v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            disp_reg <= '0;
            stor_reg <= '0;
            pend_reg <= OP_NONE;
            fresh_reg <= 1'b1;
            use_reg <= DU_OPDIV;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (key_in.valid)
                    begin
                        kind_reg <= key_in.data.kind;
                        dig_reg <= key_in.data.digit;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    state_reg <= S_OUT;
                    case (kind_reg)
                        KIND_DIGIT:
                        begin
                            if (dig_reg <= 4'd9)
                            begin
                                if (fresh_reg)
                                begin
                                    disp_reg <= {12'd0, dig_reg};
                                    fresh_reg <= 1'b0;
                                end
                                else if (d_s < DigitLimit)
                                begin
                                    disp_reg <= DataW'((disp_reg << 3) + (disp_reg << 1)
                                                + {12'd0, dig_reg});
                                end
                            end
                        end
                        KIND_CLEAR:
                        begin
                            disp_reg <= '0;
                            stor_reg <= '0;
                            pend_reg <= OP_NONE;
                            fresh_reg <= 1'b1;
                        end
                        KIND_NEGATE: disp_reg <= DataW'(-d_s);
                        KIND_SQRT:
                        begin
                            fresh_reg <= 1'b1;
                            if (!d_s[DataW-1] && d_s > 16'sd1)
                            begin
                                acc_reg <= d_s >>> 1;
                                step_reg <= '0;
                                quo_reg <= disp_reg;
                                den_reg <= DataW'(d_s >>> 1);
                                rem_reg <= '0;
                                dcnt_reg <= '0;
                                state_reg <= S_SQ_DIV;
                            end
                        end
                        KIND_EQUALS, KIND_POWER, KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV:
                        begin
                            if (pend_reg != OP_NONE)
                                state_reg <= S_FINISH;
                            else
                                state_reg <= S_POST;
                        end
                        default: ;
                    endcase
                end
                S_FINISH:
                begin
                    state_reg <= S_POST;
                    case (pend_reg)
                        OP_ADD: disp_reg <= stor_reg + disp_reg;
                        OP_SUB: disp_reg <= stor_reg - disp_reg;
                        OP_MUL: disp_reg <= DataW'(s_s * d_s);
                        OP_DIV:
                        begin
                            if (disp_reg != '0)
                            begin
                                quo_reg <= mag16(stor_reg);
                                den_reg <= mag16(disp_reg);
                                qneg_reg <= s_s[DataW-1] ^ d_s[DataW-1];
                                rem_reg <= '0;
                                dcnt_reg <= '0;
                                use_reg <= DU_OPDIV;
                                state_reg <= S_DIV;
                            end
                        end
                        OP_POW:
                        begin
                            if (d_s == 16'sd0) disp_reg <= 16'd1;
                            else if (d_s[DataW-1]) disp_reg <= '0;
                            else if (s_s == 16'sd0 || s_s == 16'sd1) disp_reg <= stor_reg;
                            else if (s_s == -16'sd1) disp_reg <= disp_reg[0] ? '1 : 16'd1;
                            else
                            begin
                                base_reg <= s_s;
                                acc_reg <= s_s;
                                exp_reg <= disp_reg;
                                step_reg <= 4'd1;
                                if (stor_reg == 16'h8000)
                                begin
                                    lim_reg <= '0;
                                    state_reg <= S_POW_MUL;
                                end
                                else
                                begin
                                    quo_reg <= PowNumer;
                                    den_reg <= mag16(stor_reg);
                                    qneg_reg <= 1'b0;
                                    rem_reg <= '0;
                                    dcnt_reg <= '0;
                                    use_reg <= DU_POWLIM;
                                    state_reg <= S_DIV;
                                end
                            end
                        end
                        default: ;
                    endcase
                    pend_reg <= OP_NONE;
                end
                S_DIV, S_SQ_DIV:
                begin
                    // one restoring step per cycle
                    if (!rem_sub[DataW])
                    begin
                        rem_reg <= rem_sub;
                        quo_reg <= {quo_reg[DataW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[DataW-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'(DataW - 1))
                        state_reg <= (state_reg == S_SQ_DIV) ? S_SQ_STEP : S_DIV_DONE;
                end
                S_DIV_DONE:
                begin
                    if (use_reg == DU_POWLIM)
                    begin
                        lim_reg <= quo_reg;
                        state_reg <= S_POW_MUL;
                    end
                    else
                    begin
                        disp_reg <= qneg_reg ? (~quo_reg + 1'b1) : quo_reg;
                        state_reg <= S_POST;
                    end
                end
                S_POW_MUL:
                begin
                    if (DataW'(step_reg) >= exp_reg || step_reg == PowMaxSteps
                        || acc_reg > lim_reg || acc_reg < -lim_reg)
                    begin
                        disp_reg <= acc_reg;
                        state_reg <= S_POST;
                    end
                    else
                    begin
                        acc_reg <= DataW'(prod);
                        step_reg <= step_reg + 4'd1;
                    end
                end
                S_SQ_STEP:
                begin
                    step_reg <= step_reg + 4'd1;
                    acc_reg <= sq_new;
                    if (sq_new == acc_reg || sq_new == acc_reg + 16'sd1
                        || step_reg == SqrtMaxRounds - 4'd1)
                    begin
                        disp_reg <= sq_new;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        quo_reg <= disp_reg;
                        den_reg <= sq_new;
                        rem_reg <= '0;
                        dcnt_reg <= '0;
                        state_reg <= S_SQ_DIV;
                    end
                end
                S_POST:
                begin
                    // operator keys store the operand and arm the next op
                    fresh_reg <= 1'b1;
                    if (kind_reg != KIND_EQUALS)
                    begin
                        stor_reg <= disp_reg;
                        pend_reg <= (kind_reg == KIND_POWER) ? OP_POW
                                    : OpW'(kind_reg - KIND_POWER);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (res_out.ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ICKE_ASSERT(a_ready_idle, clk, rst_n, key_in.ready |-> !res_out.valid, "ready while result pending")
    `ICKE_ASSERT(a_accept_next, clk, rst_n, (key_in.valid && key_in.ready) |=> (state_reg == S_DECODE), "accept did not decode")
    `ICKE_ASSERT(a_pend_range, clk, rst_n, res_out.valid |-> (pend_reg <= OP_POW), "pending op out of range")
    `ICKE_ASSERT(a_div_cnt, clk, rst_n, (state_reg == S_DIV) |-> (dcnt_reg < 5'(DataW)), "divider overrun")
endmodule
